>>> src/tkst_pkg.sv
// tkst_pkg: shared constants and types for the top-K score table.
// No dependencies.
`default_nettype none
package tkst_pkg;
  localparam int MAX_PLAYERS = 1024;
  localparam int ADDR_W = $clog2(MAX_PLAYERS);
  localparam int CNT_W = $clog2(MAX_PLAYERS + 1);
  localparam int TOTAL_W = 32;
  localparam int WORD_W = TOTAL_W + 1;
  localparam int SUM_W = 42;
  localparam int OP_W = 2;
  localparam int ID_W = 10;
  localparam int INC_W = 16;
  localparam int K_W = 11;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_TOP = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;

  // word layout: {present, total}
  typedef struct packed {
    logic                present;
    logic [TOTAL_W-1:0]  total;
  } entry_t;

  typedef enum logic [2:0] {
    PASS_ALL   = 3'b001,
    PASS_CNT   = 3'b010,
    PASS_ABOVE = 3'b100
  } pass_t;

  typedef struct packed {
    logic  clr;
    logic  en;
    pass_t pass;
  } scan_ctrl_t;
endpackage
`default_nettype wire

>>> src/tkst_ram.sv
// tkst_ram: player table, one write and one registered read port.
// Depends on tkst_pkg.
`default_nettype none
module tkst_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tkst_pkg::ADDR_W-1:0] waddr,
  input  wire tkst_pkg::entry_t            wdata,
  input  wire logic [tkst_pkg::ADDR_W-1:0] raddr,
  output tkst_pkg::entry_t                 rdata
);
  tkst_pkg::entry_t mem [tkst_pkg::MAX_PLAYERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/tkst_scan.sv
// tkst_scan: count and sum accumulator fed by the table scan.
// Depends on tkst_pkg.
`default_nettype none
module tkst_scan (
  input  wire logic                          clk,
  input  wire tkst_pkg::scan_ctrl_t          ctrl,
  input  wire tkst_pkg::entry_t              data,
  input  wire logic [tkst_pkg::TOTAL_W-1:0]  thr,
  output logic [tkst_pkg::CNT_W-1:0]         cnt,
  output logic [tkst_pkg::SUM_W-1:0]         sum
);
  logic hit;

  always_comb begin
    case (ctrl.pass)
      tkst_pkg::PASS_ALL:   hit = data.present;
      tkst_pkg::PASS_CNT:   hit = data.present && (data.total >= thr);
      tkst_pkg::PASS_ABOVE: hit = data.present && (data.total > thr);
      default:              hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      cnt <= '0;
      sum <= '0;
    end else if (ctrl.en && hit) begin
      cnt <= cnt + tkst_pkg::CNT_W'(1);
      sum <= sum + tkst_pkg::SUM_W'(data.total);
    end
  end
endmodule
`default_nettype wire

>>> src/top_k_score_table.sv
// top_k_score_table: top level, control sequencer around the player table.
// Depends on tkst_pkg, tkst_ram, tkst_scan.
//
// Player totals and present flags share one synchronous memory word per
// player. After reset the block sweeps the memory once, one entry per
// cycle, clearing the present flags and totals; no item is taken during
// the sweep. An add or reset item reads the entry, modifies it and writes
// it back. A top query scans the table once to count and sum present
// players; if k_count is nonzero and more than k_count are present, the
// k-th largest total is found by a radix search, one memory scan per bit
// (32 scans), and a final scan sums the totals above it. One item is
// worked on at a time; the finished sum waits in an output register so
// the next item can be accepted while it is held.
`default_nettype none
module top_k_score_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tkst_pkg::OP_W-1:0]     op,
  input  wire logic [tkst_pkg::ID_W-1:0]     player_id,
  input  wire logic [tkst_pkg::INC_W-1:0]    score_increment,
  input  wire logic [tkst_pkg::K_W-1:0]      k_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tkst_pkg::SUM_W-1:0]         top_sum
);
  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_URD   = 10'b0000000100,
    S_UWR   = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_WAIT  = 10'b0000100000,
    S_EVAL  = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_SUM   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  localparam int BIT_W = $clog2(tkst_pkg::TOTAL_W);
  localparam logic [tkst_pkg::ADDR_W-1:0] LAST_ADDR =
    tkst_pkg::ADDR_W'(tkst_pkg::MAX_PLAYERS - 1);

  state_t state;
  tkst_pkg::pass_t pass;
  logic [tkst_pkg::ADDR_W-1:0] addr;      // sweep / scan address
  logic [tkst_pkg::ADDR_W-1:0] uaddr;     // latched update target
  logic [tkst_pkg::OP_W-1:0] uop;
  logic [tkst_pkg::INC_W-1:0] uinc;
  logic [tkst_pkg::K_W-1:0] kq;
  logic rd_v;
  logic [BIT_W-1:0] bitn;
  logic [tkst_pkg::TOTAL_W-1:0] prefix, cand;
  logic [tkst_pkg::SUM_W-1:0] prod, res;

  tkst_pkg::entry_t rdata, wdata;
  logic we;
  logic [tkst_pkg::ADDR_W-1:0] waddr, raddr;
  tkst_pkg::scan_ctrl_t sctrl;
  logic [tkst_pkg::CNT_W-1:0] cnt;
  logic [tkst_pkg::SUM_W-1:0] sum;
  logic [tkst_pkg::TOTAL_W-1:0] thr;
  logic [tkst_pkg::TOTAL_W:0] add_full;
  logic [tkst_pkg::TOTAL_W-1:0] pfx_new;
  logic id_ok;

  assign in_stall = (state != S_IDLE);
  assign id_ok = 32'(player_id) < 32'(tkst_pkg::MAX_PLAYERS);

  // read-modify-write of one entry
  assign add_full = {1'b0, rdata.total} + (tkst_pkg::TOTAL_W+1)'(uinc);
  always_comb begin
    wdata = rdata;
    if (state == S_CLEAR) begin
      wdata.present = 1'b0;
      wdata.total = '0;
    end else if (uop == tkst_pkg::OP_RESET) begin
      wdata.present = 1'b0;
    end else if (rdata.present) begin
      wdata.total = add_full[tkst_pkg::TOTAL_W] ? '1 : add_full[tkst_pkg::TOTAL_W-1:0];
    end else begin
      wdata.present = 1'b1;
      wdata.total = tkst_pkg::TOTAL_W'(uinc);
    end
  end

  assign we = (state == S_CLEAR) || (state == S_UWR);
  assign waddr = (state == S_CLEAR) ? addr : uaddr;
  assign raddr = (state == S_URD) ? uaddr : addr;

  assign thr = (pass == tkst_pkg::PASS_CNT) ? cand : prefix;
  // the above-threshold scan keeps its count and sum for the final steps
  assign sctrl.clr = (state == S_IDLE) ||
                     ((state == S_EVAL) && (pass != tkst_pkg::PASS_ABOVE));
  assign sctrl.en = rd_v;
  assign sctrl.pass = pass;

  // radix search step: keep the candidate bit if enough totals reach it
  assign pfx_new = ({1'b0, cnt} >= {1'b0, kq}) ? cand : prefix;

  tkst_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tkst_scan u_scan (
    .clk  (clk),
    .ctrl (sctrl),
    .data (rdata),
    .thr  (thr),
    .cnt  (cnt),
    .sum  (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr <= '0;
      rd_v <= 1'b0;
      out_valid <= 1'b0;
      pass <= tkst_pkg::PASS_ALL;
    end else begin
      rd_v <= (state == S_SCAN);
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          addr <= addr + tkst_pkg::ADDR_W'(1);
          if (addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            uop <= op;
            uaddr <= tkst_pkg::ADDR_W'(player_id);
            uinc <= score_increment;
            kq <= k_count;
            if (op == tkst_pkg::OP_TOP) begin
              pass <= tkst_pkg::PASS_ALL;
              addr <= '0;
              state <= S_SCAN;
            end else if (id_ok && (op == tkst_pkg::OP_ADD || op == tkst_pkg::OP_RESET)) begin
              state <= S_URD;
            end
          end
        end
        S_URD: state <= S_UWR;
        S_UWR: state <= S_IDLE;
        S_SCAN: begin
          addr <= addr + tkst_pkg::ADDR_W'(1);
          if (addr == LAST_ADDR) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          addr <= '0;
          case (pass)
            tkst_pkg::PASS_ALL: begin
              if (kq == '0) begin
                res <= '0;
                state <= S_FIN;
              end else if ({1'b0, cnt} <= {1'b0, kq}) begin
                res <= sum;
                state <= S_FIN;
              end else begin
                bitn <= BIT_W'(tkst_pkg::TOTAL_W - 1);
                prefix <= '0;
                cand <= {1'b1, {(tkst_pkg::TOTAL_W-1){1'b0}}};
                pass <= tkst_pkg::PASS_CNT;
                state <= S_SCAN;
              end
            end
            tkst_pkg::PASS_CNT: begin
              prefix <= pfx_new;
              if (bitn == '0) begin
                pass <= tkst_pkg::PASS_ABOVE;
              end else begin
                bitn <= bitn - BIT_W'(1);
                cand <= pfx_new | (tkst_pkg::TOTAL_W'(1) << (bitn - BIT_W'(1)));
              end
              state <= S_SCAN;
            end
            tkst_pkg::PASS_ABOVE: state <= S_MUL;
            default: state <= S_IDLE;
          endcase
        end
        S_MUL: begin
          // remaining players all sit at the k-th largest total
          prod <= tkst_pkg::SUM_W'(kq - tkst_pkg::K_W'(cnt)) * tkst_pkg::SUM_W'(prefix);
          state <= S_SUM;
        end
        S_SUM: begin
          res <= sum + prod;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            top_sum <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for top_k_score_table.
// Depends on tkst_pkg and the top_k_score_table RTL; compares every top_sum
// item against an in-bench leaderboard model fed from the accepted items.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tkst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // ignored op code
  localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;
  localparam longint unsigned TOTAL_CAP = 64'hFFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 150000;  // above the worst query's length
  localparam int RANDOM_ITEMS = 560;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = OP_ADD;
  logic [ID_W-1:0] player_id = '0;
  logic [INC_W-1:0] score_increment = '0;
  logic [K_W-1:0] k_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SUM_W-1:0] top_sum;

  // bench-side tag riding along with the item: a hand-typed expectation
  logic tag_fixed = 1'b0;
  logic [SUM_W-1:0] tag_sum = '0;

  top_k_score_table u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .player_id(player_id),
    .score_increment(score_increment), .k_count(k_count),
    .out_valid(out_valid), .out_stall(out_stall), .top_sum(top_sum)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- leaderboard model ----------------
  bit board_present[MAX_PLAYERS];
  logic [TOTAL_W-1:0] board_total[MAX_PLAYERS];
  logic [SUM_W-1:0] pending_sums[$];  // sums owed by the DUT, oldest first

  int n_items, n_sums, n_errors, idle_cycles;
  int snd_idle_pct, rcv_idle_pct;

  function automatic int players_present();
    int n;
    n = 0;
    for (int i = 0; i < MAX_PLAYERS; i++) n += board_present[i];
    return n;
  endfunction

  // sum of the k largest present totals; ties counted once per player
  function automatic logic [SUM_W-1:0] leader_sum(int unsigned k);
    longint unsigned vals[$];
    longint unsigned acc;
    int n;
    acc = 0;
    for (int i = 0; i < MAX_PLAYERS; i++)
      if (board_present[i]) vals.push_back(board_total[i]);
    vals.rsort();
    n = (k < vals.size()) ? k : vals.size();
    for (int i = 0; i < n; i++) acc += vals[i];
    if (acc > SUM_CAP) acc = SUM_CAP;
    return acc[SUM_W-1:0];
  endfunction

  // apply one accepted item to the board; queries queue their sum
  task automatic board_apply(logic [OP_W-1:0] o, logic [ID_W-1:0] id,
                             logic [INC_W-1:0] inc, logic [K_W-1:0] k,
                             logic fixed, logic [SUM_W-1:0] fixed_sum);
    longint unsigned t;
    logic [SUM_W-1:0] s;
    case (o)
      OP_TOP: begin
        s = leader_sum(k);
        if (fixed && fixed_sum !== s) begin
          $error("hand-typed top_sum %0d disagrees with model %0d", fixed_sum, s);
          n_errors++;
        end
        pending_sums.push_back(fixed ? fixed_sum : s);
      end
      OP_ADD: begin
        if (board_present[id]) begin
          t = longint'(board_total[id]) + inc;
          board_total[id] = (t > TOTAL_CAP) ? TOTAL_CAP[TOTAL_W-1:0] : t[TOTAL_W-1:0];
        end else begin
          board_present[id] = 1'b1;
          board_total[id] = TOTAL_W'(inc);
        end
      end
      OP_RESET: board_present[id] = 1'b0;
      default: ;  // unused op code: nothing changes
    endcase
  endtask

  // ---------------- monitors ----------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      board_apply(op, player_id, score_increment, k_count, tag_fixed, tag_sum);
      n_items++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("top_sum %0d arrived with nothing expected", top_sum);
        n_errors++;
      end else begin
        if (top_sum !== pending_sums[0]) begin
          $error("top_sum: expected %0d, got %0d", pending_sums[0], top_sum);
          n_errors++;
        end
        void'(pending_sums.pop_front());
      end
      n_sums++;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------- driver ----------------
  task automatic send_item(logic [OP_W-1:0] o, logic [ID_W-1:0] id,
                           logic [INC_W-1:0] inc, logic [K_W-1:0] k,
                           logic fixed, logic [SUM_W-1:0] fixed_sum);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    player_id <= id;
    score_increment <= inc;
    k_count <= k;
    tag_fixed <= fixed;
    tag_sum <= fixed_sum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  typedef struct {
    logic [OP_W-1:0] o;
    logic [ID_W-1:0] id;
    logic [INC_W-1:0] inc;
    logic [K_W-1:0] k;
    logic fixed;
    logic [SUM_W-1:0] s;
  } row_t;

  // directed rows; s is typed in only where it is obvious
  row_t plan[] = '{
    '{OP_TOP,   10'd0,    16'd0,     11'd5,    1'b1, 42'd0},      // empty board
    '{OP_ADD,   10'd0,    16'd0,     11'd0,    1'b0, 42'd0},      // zero score
    '{OP_ADD,   10'd1023, 16'hFFFF,  11'h7FF,  1'b0, 42'd0},
    '{OP_TOP,   10'h3FF,  16'hFFFF,  11'h7FF,  1'b1, 42'd65535},  // k above count
    '{OP_TOP,   10'd0,    16'd0,     11'd0,    1'b1, 42'd0},      // k of zero
    '{OP_ADD,   10'd1023, 16'hFFFF,  11'd0,    1'b0, 42'd0},      // accumulate
    '{OP_UNUSED, 10'd5,   16'd100,   11'd1,    1'b0, 42'd0},      // ignored
    '{OP_TOP,   10'd0,    16'd0,     11'd1,    1'b1, 42'd131070},
    '{OP_RESET, 10'd7,    16'd0,     11'd0,    1'b0, 42'd0},      // absent player
    '{OP_ADD,   10'd5,    16'd100,   11'd0,    1'b0, 42'd0},
    '{OP_ADD,   10'd6,    16'd100,   11'd0,    1'b0, 42'd0},
    '{OP_ADD,   10'd9,    16'd100,   11'd0,    1'b0, 42'd0},
    '{OP_TOP,   10'd0,    16'd0,     11'd2,    1'b0, 42'd0},      // tie at k-th
    '{OP_TOP,   10'd0,    16'd0,     11'd3,    1'b0, 42'd0},
    '{OP_RESET, 10'd1023, 16'hFFFF,  11'h7FF,  1'b0, 42'd0},
    '{OP_TOP,   10'd0,    16'd0,     11'd1024, 1'b0, 42'd0},
    '{OP_ADD,   10'd1023, 16'd1,     11'd0,    1'b0, 42'd0},      // fresh, not summed
    '{OP_TOP,   10'd0,    16'd0,     11'd1,    1'b0, 42'd0}
  };

  // one random item, mostly adds on a small player pool to get collisions
  task automatic send_random();
    int r, cnt;
    logic [ID_W-1:0] id;
    logic [INC_W-1:0] inc;
    logic [K_W-1:0] k;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 99) < 70) ? ID_W'($urandom_range(0, 63)) : ID_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1: inc = 16'hFFFF;
      2: inc = '0;
      default: inc = INC_W'($urandom);
    endcase
    k = K_W'($urandom);
    if (r < 66) send_item(OP_ADD, id, inc, k, 1'b0, '0);
    else if (r < 84) send_item(OP_RESET, id, inc, k, 1'b0, '0);
    else if (r < 88) send_item(OP_UNUSED, ID_W'($urandom), inc, k, 1'b0, '0);
    else begin
      // a nonzero k below the player count forces the slow radix search; keep it rare
      cnt = players_present();
      if ($urandom_range(0, 99) < 20) k = K_W'($urandom_range(0, cnt));
      else k = K_W'($urandom_range(cnt, 2047));
      send_item(OP_TOP, ID_W'($urandom), INC_W'($urandom), k, 1'b0, '0);
    end
  endtask

  task automatic drain();
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  initial begin
    snd_idle_pct = 10;
    rcv_idle_pct = 67;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_item(plan[i].o, plan[i].id, plan[i].inc, plan[i].k, plan[i].fixed, plan[i].s);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        snd_idle_pct = 67;
        rcv_idle_pct = 10;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      send_random();
    end
    in_valid <= 1'b0;

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d items (directed rows, then three idle mixes of random items),",
             n_items);
    $display("checked %0d top_sum results", n_sums);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
src/tkst_pkg.sv
src/tkst_ram.sv
src/tkst_scan.sv
src/top_k_score_table.sv
tb/testbench.sv
